// ===== rtl/core/color_sensor_autorange_lux_assert.svh =====
// Assertion macros shared by the color sensor autorange lux RTL
`ifndef COLOR_SENSOR_AUTORANGE_LUX_ASSERT_SVH
`define COLOR_SENSOR_AUTORANGE_LUX_ASSERT_SVH

// same-cycle implication
`define CSAL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CSAL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/csal_pkg.sv =====
// Package: types, register indexes, range table and controller states
package csal_pkg;

  typedef struct packed {
    logic [15:0] red_raw;
    logic [15:0] green_raw;
    logic [15:0] blue_raw;
    logic [15:0] clear_raw;
  } in_word_t;

  typedef struct packed {
    logic        range_changed;
    logic [2:0]  range_index;
    logic [5:0]  gain_mult;
    logic [9:0]  integration_ms;
    logic [7:0]  red_norm;
    logic [7:0]  green_norm;
    logic [7:0]  blue_norm;
    logic [15:0] lux_value;
    logic        sat_flag;
    logic        change_flag;
  } out_word_t;

  localparam logic [2:0] REG_COLOR_THR = 3'd0;
  localparam logic [2:0] REG_LUX_THR   = 3'd1;
  localparam logic [2:0] REG_RED_COEF  = 3'd2;
  localparam logic [2:0] REG_GREEN_COEF = 3'd3;
  localparam logic [2:0] REG_BLUE_COEF = 3'd4;
  localparam logic [2:0] REG_DEV_FACTOR = 3'd5;

  localparam logic [1:0] SEL_LUX   = 2'd0;
  localparam logic [1:0] SEL_RED   = 2'd1;
  localparam logic [1:0] SEL_GREEN = 2'd2;
  localparam logic [1:0] SEL_BLUE  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COMP, ST_MAC, ST_PROD, ST_DIVGO, ST_DIVWAIT, ST_FIN
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       comp;
    logic       mac_en;
    logic       mac_first;
    logic       prod_en;
    logic       div_start;
    logic       div_store;
    logic       fin_load;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic move;
    logic div_done;
    logic out_busy;
  } status_t;

  function automatic logic [5:0] step_gain(input logic [2:0] idx);
    unique case (idx)
      3'd0, 3'd1: step_gain = 6'd60;
      3'd2:       step_gain = 6'd16;
      3'd3:       step_gain = 6'd4;
      default:    step_gain = 6'd1;
    endcase
  endfunction

  function automatic logic [9:0] step_ms(input logic [2:0] idx);
    unique case (idx)
      3'd0:    step_ms = 10'd614;
      default: step_ms = 10'd153;
    endcase
  endfunction

  // ms times gain
  function automatic logic [15:0] step_msg(input logic [2:0] idx);
    unique case (idx)
      3'd0:    step_msg = 16'd36840;
      3'd1:    step_msg = 16'd9180;
      3'd2:    step_msg = 16'd2448;
      3'd3:    step_msg = 16'd612;
      default: step_msg = 16'd153;
    endcase
  endfunction

  function automatic logic [15:0] step_high(input logic [2:0] idx);
    unique case (idx)
      3'd0:       step_high = 16'd20000;
      3'd1, 3'd2, 3'd3: step_high = 16'd63000;
      default:    step_high = 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] step_low(input logic [2:0] idx);
    unique case (idx)
      3'd0:       step_low = 16'd0;
      3'd1:       step_low = 16'd4990;
      3'd2:       step_low = 16'd16790;
      default:    step_low = 16'd15740;
    endcase
  endfunction

endpackage

// ===== rtl/core/csal_div.sv =====
// Shared divider: 37-bit by 16-bit, two quotient bits per cycle, saturating
module csal_div import csal_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [36:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quo
);

  logic        busy;
  logic [2:0]  cnt;
  logic [15:0] rem;
  logic [15:0] nlo;
  logic        ovf;
  logic [15:0] rem_next;
  logic [15:0] nlo_next;
  logic [15:0] quo_next;

  assign ovf = num[36:16] >= {5'd0, den};

  always_comb begin
    logic [16:0] t;
    rem_next = rem;
    nlo_next = nlo;
    quo_next = quo;
    for (int k = 0; k < 2; k++) begin
      t = {rem_next, nlo_next[15]};
      nlo_next = {nlo_next[14:0], 1'b0};
      if (t >= {1'b0, den}) begin
        rem_next = 16'(t - {1'b0, den});
        quo_next = {quo_next[14:0], 1'b1};
      end else begin
        rem_next = t[15:0];
        quo_next = {quo_next[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !ovf;
        cnt  <= 3'd0;
        done <= ovf;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[31:16];
      nlo <= num[15:0];
      quo <= ovf ? 16'hFFFF : 16'd0;
    end else if (busy) begin
      rem <= rem_next;
      nlo <= nlo_next;
      quo <= quo_next;
    end
  end

endmodule

// ===== rtl/core/csal_ctrl.sv =====
// Controller: sequences range check, products, divisions and result load
module csal_ctrl import csal_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t     state, state_next;
  logic [1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 2'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = 2'd0;
        if (in_valid) state_next = st.move ? ST_FIN : ST_COMP;
      end
      ST_COMP: state_next = ST_MAC;
      ST_MAC: begin
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd2) begin
          state_next = ST_PROD;
          cnt_next   = 2'd0;
        end
      end
      ST_PROD: begin
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd1) begin
          state_next = ST_DIVGO;
          cnt_next   = 2'd0;
        end
      end
      ST_DIVGO: state_next = ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (st.div_done) begin
          cnt_next   = cnt + 2'd1;
          state_next = (cnt == 2'd3) ? ST_FIN : ST_DIVGO;
        end
      end
      ST_FIN: begin
        if (!st.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.sel  = cnt;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_COMP: cmd.comp = 1'b1;
      ST_MAC: begin
        cmd.mac_en    = 1'b1;
        cmd.mac_first = (cnt == 2'd0);
      end
      ST_PROD:    cmd.prod_en = 1'b1;
      ST_DIVGO:   cmd.div_start = 1'b1;
      ST_DIVWAIT: cmd.div_store = st.div_done;
      ST_FIN:     cmd.fin_load = !st.out_busy;
      default:    cmd = '0;
    endcase
  end

  `include "color_sensor_autorange_lux_assert.svh"

  `CSAL_ASSERT_NOW(a_fin_free, clk, rst, cmd.fin_load, !st.out_busy, "result load while output busy")
  `CSAL_ASSERT_NEXT(a_move_fin, clk, rst, cmd.load_in && st.move, state == ST_FIN, "range step must go to result")
  `CSAL_ASSERT_NEXT(a_div_hold, clk, rst, state == ST_DIVWAIT && !st.div_done, state == ST_DIVWAIT, "left divide wait early")
  `CSAL_ASSERT_NEXT(a_start_once, clk, rst, cmd.div_start, !cmd.div_start, "divider started twice")

endmodule

// ===== rtl/core/csal_dp.sv =====
// Datapath: config registers, range state, IR compensation, lux and normalization
module csal_dp import csal_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  in_word_t    in_data,
  output out_word_t   out_data,
  output logic        out_valid,
  input  logic        out_ready,
  input  cmd_t        cmd,
  output status_t     st,
  output logic        div_start,
  output logic [36:0] div_num,
  output logic [15:0] div_den,
  input  logic        div_done,
  input  logic [15:0] div_quo
);

  logic [7:0]         color_thr;
  logic [15:0]        lux_thr;
  logic signed [15:0] red_coef, green_coef, blue_coef;
  logic [23:0]        dev_factor;

  logic [2:0]  range_step;
  logic        reread;
  logic        rchg;
  in_word_t    raw;
  logic [15:0] rc, gc, bc, cc;
  logic signed [34:0] acc;
  logic [56:0] num;
  logic [15:0] lux;
  logic [7:0]  nr, ng, nb;
  logic [7:0]  prev_red, prev_green, prev_blue;
  logic [15:0] prev_lux;

  logic        up, dn;
  logic [15:0] hi, lo;
  logic        s_pos;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_thr  <= 8'd5;
      lux_thr    <= 16'd10;
      red_coef   <= 16'sd557;
      green_coef <= 16'sd4096;
      blue_coef  <= -16'sd1819;
      dev_factor <= 24'd79360;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_COLOR_THR:  color_thr  <= pwdata[7:0];
        REG_LUX_THR:    lux_thr    <= pwdata[15:0];
        REG_RED_COEF:   red_coef   <= pwdata[15:0];
        REG_GREEN_COEF: green_coef <= pwdata[15:0];
        REG_BLUE_COEF:  blue_coef  <= pwdata[15:0];
        REG_DEV_FACTOR: dev_factor <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COLOR_THR:  prdata = {24'd0, color_thr};
      REG_LUX_THR:    prdata = {16'd0, lux_thr};
      REG_RED_COEF:   prdata = {16'd0, red_coef};
      REG_GREEN_COEF: prdata = {16'd0, green_coef};
      REG_BLUE_COEF:  prdata = {16'd0, blue_coef};
      REG_DEV_FACTOR: prdata = {8'd0, dev_factor};
      default:        prdata = 32'd0;
    endcase
  end

  // range check on the incoming word
  assign hi = step_high(range_step);
  assign lo = step_low(range_step);
  assign up = !reread && hi != 16'd0 && in_data.clear_raw > hi;
  assign dn = !reread && !up && lo != 16'd0 && in_data.clear_raw < lo;

  assign s_pos = !acc[34] && acc != 35'sd0;

  assign st.move     = up || dn;
  assign st.div_done = div_done;
  assign st.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_step <= 3'd0;
      reread     <= 1'b0;
    end else if (cmd.load_in) begin
      if (up) range_step <= range_step + 3'd1;
      else if (dn) range_step <= range_step - 3'd1;
      reread <= up || dn;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw  <= in_data;
      rchg <= up || dn;
    end
  end

  // IR compensation
  always_ff @(posedge clk) begin
    logic [17:0] sum;
    logic [16:0] ir;
    sum = 18'(raw.red_raw) + 18'(raw.green_raw) + 18'(raw.blue_raw);
    ir  = (sum > 18'(raw.clear_raw)) ? 17'((sum - 18'(raw.clear_raw)) >> 1) : 17'd0;
    if (cmd.comp) begin
      rc <= (17'(raw.red_raw) > ir)   ? 16'(17'(raw.red_raw) - ir)   : 16'd0;
      gc <= (17'(raw.green_raw) > ir) ? 16'(17'(raw.green_raw) - ir) : 16'd0;
      bc <= (17'(raw.blue_raw) > ir)  ? 16'(17'(raw.blue_raw) - ir)  : 16'd0;
      cc <= (17'(raw.clear_raw) > ir) ? 16'(17'(raw.clear_raw) - ir) : 16'd0;
    end
  end

  // weighted sum, one channel a cycle
  always_ff @(posedge clk) begin
    logic signed [15:0] coef;
    logic [15:0]        ch;
    logic signed [32:0] mprod;
    case (cmd.sel)
      2'd0:    begin coef = red_coef;   ch = rc; end
      2'd1:    begin coef = green_coef; ch = gc; end
      default: begin coef = blue_coef;  ch = bc; end
    endcase
    mprod = coef * $signed({1'b0, ch});
    if (cmd.mac_en) acc <= (cmd.mac_first ? 35'sd0 : acc) + 35'(mprod);
  end

  // sum times device factor in two partial products
  always_ff @(posedge clk) begin
    logic [16:0] part;
    logic [40:0] pp;
    part = cmd.sel[0] ? {1'b0, acc[32:17]} : acc[16:0];
    pp   = 41'(part) * 41'(dev_factor);
    if (cmd.prod_en) num <= cmd.sel[0] ? num + (57'(pp) << 17) : 57'(pp);
  end

  always_comb begin
    logic [15:0] ch;
    unique case (cmd.sel)
      SEL_RED:   ch = rc;
      SEL_GREEN: ch = gc;
      default:   ch = bc;
    endcase
    div_start = cmd.div_start;
    if (cmd.sel == SEL_LUX) begin
      div_num = num[56:20];
      div_den = step_msg(range_step);
    end else begin
      div_num = 37'({ch, 8'd0} - {8'd0, ch});
      div_den = cc;
    end
  end

  always_ff @(posedge clk) begin
    logic [7:0] n;
    n = (cc == 16'd0) ? 8'd0 : ((div_quo > 16'd255) ? 8'd255 : div_quo[7:0]);
    if (cmd.div_store) begin
      case (cmd.sel)
        SEL_LUX:   lux <= s_pos ? div_quo : 16'd0;
        SEL_RED:   nr  <= n;
        SEL_GREEN: ng  <= n;
        default:   nb  <= n;
      endcase
    end
  end

  function automatic logic [15:0] absdiff(input logic [15:0] a, input logic [15:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_red   <= 8'd0;
      prev_green <= 8'd0;
      prev_blue  <= 8'd0;
      prev_lux   <= 16'd0;
    end else begin
      if (cmd.fin_load) begin
        out_valid <= 1'b1;
        if (!rchg) begin
          prev_red   <= nr;
          prev_green <= ng;
          prev_blue  <= nb;
          prev_lux   <= lux;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      out_data.range_changed  <= rchg;
      out_data.range_index    <= range_step;
      out_data.gain_mult      <= step_gain(range_step);
      out_data.integration_ms <= step_ms(range_step);
      out_data.sat_flag       <= 1'b0;
      if (rchg) begin
        out_data.red_norm    <= 8'd0;
        out_data.green_norm  <= 8'd0;
        out_data.blue_norm   <= 8'd0;
        out_data.lux_value   <= 16'd0;
        out_data.change_flag <= 1'b0;
      end else begin
        out_data.red_norm    <= nr;
        out_data.green_norm  <= ng;
        out_data.blue_norm   <= nb;
        out_data.lux_value   <= lux;
        out_data.change_flag <=
          absdiff({8'd0, nr}, {8'd0, prev_red})   > {8'd0, color_thr} ||
          absdiff({8'd0, ng}, {8'd0, prev_green}) > {8'd0, color_thr} ||
          absdiff({8'd0, nb}, {8'd0, prev_blue})  > {8'd0, color_thr} ||
          absdiff(lux, prev_lux) > lux_thr;
      end
    end
  end

endmodule

// ===== rtl/core/color_sensor_autorange_lux.sv =====
// Top level: color sensor autorange, IR-compensated lux and normalized RGB
// Range-step words: the controller goes from idle straight to the result load, with no arithmetic.
// Measurement words: IR compensation, the weighted sum and two partial products, then the shared
// two-bit-per-cycle divider four times for lux and the three channels, shorter when it saturates.
// One word is in work at a time; a new word is taken only once the result has been loaded.
// Synchronous reset restores register defaults, range step 0 and zero history.
module color_sensor_autorange_lux import csal_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data
);

  cmd_t        cmd;
  status_t     st;
  logic        div_start;
  logic [36:0] div_num;
  logic [15:0] div_den;
  logic        div_done;
  logic [15:0] div_quo;

  csal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  csal_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quo   (div_quo)
  );

  csal_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

// ===== dv/tb_top.sv =====
// Testbench for color_sensor_autorange_lux: directed and random samples with a scoreboard predictor
`timescale 1ns / 100ps
module tb_top;
  import csal_pkg::*;

  localparam int unsigned GAIN_TBL[5]  = '{60, 60, 16, 4, 1};
  localparam int unsigned CYC_TBL[5]   = '{256, 64, 64, 64, 64};
  localparam int unsigned LOW_TBL[5]   = '{0, 4990, 16790, 15740, 15740};
  localparam int unsigned HIGH_TBL[5]  = '{20000, 63000, 63000, 63000, 0};
  localparam int unsigned BAND_PTS[7]  = '{20000, 4990, 63000, 16790, 15740, 0, 65535};
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_word_t   out_data;

  color_sensor_autorange_lux i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor copy of registers and state
  int unsigned color_thr = 5, lux_thr = 10, dev_factor = 79360;
  int          coef_r = 557, coef_g = 4096, coef_b = -1819;
  int unsigned cur_step = 0;
  bit          reread = 0;
  int unsigned last_r = 0, last_g = 0, last_b = 0, last_lux = 0;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int  gap = 0, stall = 0, cycles = 0;
  int  fail_count = 0, words_sent = 0, words_seen = 0, range_moves = 0;
  bit  no_idle = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned sub_floor(int unsigned a, int unsigned b);
    return a > b ? a - b : 0;
  endfunction

  function automatic int unsigned scale_norm(int unsigned ch, int unsigned clr);
    int unsigned q;
    q = (ch * 255) / clr;
    return q > 255 ? 255 : q;
  endfunction

  function automatic int unsigned dist_abs(int unsigned a, int unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic out_word_t predict_reading(in_word_t w);
    out_word_t o;
    int unsigned idx, ms, sum, ir, rc, gc, bc, cc, satl, lux, nr, ng, nb;
    bit moved;
    longint s;
    longint unsigned num, den, q;
    idx = cur_step;
    moved = 0;
    o = '0;
    if (!reread) begin
      if (HIGH_TBL[idx] != 0 && w.clear_raw > HIGH_TBL[idx]) begin
        idx++;
        moved = 1;
      end else if (LOW_TBL[idx] != 0 && w.clear_raw < LOW_TBL[idx]) begin
        idx--;
        moved = 1;
      end
    end
    ms = (CYC_TBL[idx] * 24) / 10;
    o.range_index = 3'(idx);
    o.gain_mult = 6'(GAIN_TBL[idx]);
    o.integration_ms = 10'(ms);
    if (moved) begin
      cur_step = idx;
      reread = 1;
      o.range_changed = 1'b1;
      return o;
    end
    reread = 0;
    sum = w.red_raw + w.green_raw + w.blue_raw;
    ir = sum > w.clear_raw ? (sum - w.clear_raw) / 2 : 0;
    rc = sub_floor(w.red_raw, ir);
    gc = sub_floor(w.green_raw, ir);
    bc = sub_floor(w.blue_raw, ir);
    cc = sub_floor(w.clear_raw, ir);
    satl = CYC_TBL[idx] > 63 ? 65535 : 1024 * CYC_TBL[idx];
    if (ms < 150) begin
      satl = satl - satl / 4;
      o.sat_flag = w.clear_raw > satl;
    end
    s = longint'(coef_r) * rc + longint'(coef_g) * gc + longint'(coef_b) * bc;
    lux = 0;
    if (s > 0) begin
      num = longint'(s) * dev_factor;
      den = longint'(ms * GAIN_TBL[idx]) << 20;
      q = num / den;
      lux = q > 65535 ? 65535 : 32'(q);
    end
    nr = 0; ng = 0; nb = 0;
    if (cc > 0) begin
      nr = scale_norm(rc, cc);
      ng = scale_norm(gc, cc);
      nb = scale_norm(bc, cc);
    end
    o.change_flag = dist_abs(nr, last_r) > color_thr || dist_abs(ng, last_g) > color_thr ||
                    dist_abs(nb, last_b) > color_thr || dist_abs(lux, last_lux) > lux_thr;
    last_r = nr; last_g = ng; last_b = nb; last_lux = lux;
    o.red_norm = 8'(nr);
    o.green_norm = 8'(ng);
    o.blue_norm = 8'(nb);
    o.lux_value = 16'(lux);
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_words.push_back(predict_reading(in_data));
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1;
          in_data <= pending_words.pop_front();
          gap <= no_idle ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned exp, int unsigned got);
    if (exp != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      out_ready <= 0;
      stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %h", $time, out_data);
          fail_count++;
        end else begin
          e = expected_words.pop_front();
          if (e.range_changed) range_moves++;
          check_field("range_changed", e.range_changed, out_data.range_changed);
          check_field("range_index", e.range_index, out_data.range_index);
          check_field("gain_mult", e.gain_mult, out_data.gain_mult);
          check_field("integration_ms", e.integration_ms, out_data.integration_ms);
          check_field("red_norm", e.red_norm, out_data.red_norm);
          check_field("green_norm", e.green_norm, out_data.green_norm);
          check_field("blue_norm", e.blue_norm, out_data.blue_norm);
          check_field("lux_value", e.lux_value, out_data.lux_value);
          check_field("sat_flag", e.sat_flag, out_data.sat_flag);
          check_field("change_flag", e.change_flag, out_data.change_flag);
        end
        if (no_idle) begin
          out_ready <= 1;
        end else begin
          stall <= $urandom_range(0, 9);
          out_ready <= 0;
        end
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_COLOR_THR:  color_thr = value[7:0];
      REG_LUX_THR:    lux_thr = value[15:0];
      REG_RED_COEF:   coef_r = $signed(value[15:0]);
      REG_GREEN_COEF: coef_g = $signed(value[15:0]);
      REG_BLUE_COEF:  coef_b = $signed(value[15:0]);
      default:        dev_factor = value[23:0];
    endcase
  endtask

  task automatic write_all(int unsigned cthr, int unsigned lthr, int cr, int cg, int cb,
                           int unsigned df);
    reg_write(REG_COLOR_THR, cthr);
    reg_write(REG_LUX_THR, lthr);
    reg_write(REG_RED_COEF, cr & 32'hFFFF);
    reg_write(REG_GREEN_COEF, cg & 32'hFFFF);
    reg_write(REG_BLUE_COEF, cb & 32'hFFFF);
    reg_write(REG_DEV_FACTOR, df);
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_word_t make_sample(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                           logic [15:0] c);
    in_word_t w;
    w.red_raw = r;
    w.green_raw = g;
    w.blue_raw = b;
    w.clear_raw = c;
    return w;
  endfunction

  function automatic in_word_t random_sample();
    int unsigned c, pt;
    c = 0;
    case ($urandom_range(0, 9))
      0, 1: c = pick16();
      2, 3, 4, 5, 6: begin
        pt = BAND_PTS[$urandom_range(0, 6)];
        c = pt + $urandom_range(0, 600);
        c = c < 300 ? 0 : c - 300;
        if (c > 65535) c = 65535;
      end
      default: c = $urandom_range(5000, 19000);
    endcase
    if ($urandom_range(0, 3) == 0)
      return make_sample(pick16(), pick16(), pick16(), 16'(c));
    return make_sample(16'((c * $urandom_range(0, 110)) / 100),
                       16'((c * $urandom_range(0, 110)) / 100),
                       16'((c * $urandom_range(0, 110)) / 100), 16'(c));
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    no_idle = 1;
    pending_words.push_back(make_sample(0, 0, 0, 0));
    pending_words.push_back(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(make_sample(100, 200, 300, 63001));
    pending_words.push_back(make_sample(9000, 9000, 9000, 20000));
    pending_words.push_back(make_sample(60000, 60000, 60000, 65535));
    pending_words.push_back(make_sample(60000, 60000, 60000, 65535));
    pending_words.push_back(make_sample(500, 500, 500, 0));
    pending_words.push_back(make_sample(0, 0, 0, 15739));
    pending_words.push_back(make_sample(0, 0, 0, 15739));
    pending_words.push_back(make_sample(0, 0, 40000, 16000));
    pending_words.push_back(make_sample(0, 0, 0, 0));
    pending_words.push_back(make_sample(3000, 2000, 1000, 16789));
    pending_words.push_back(make_sample(3000, 2000, 1000, 16789));
    pending_words.push_back(make_sample(3000, 2000, 1000, 4989));
    pending_words.push_back(make_sample(3000, 2000, 1000, 4989));
    pending_words.push_back(make_sample(4000, 4000, 4000, 10000));
    pending_words.push_back(make_sample(1, 1, 1, 20001));
    drain();
    no_idle = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: write_all(0, 0, 32767, 32767, 32767, 24'hFFFFFF);
        2: write_all(255, 65535, -32768, -32768, -32768, 1);
        3: write_all(0, 0, -32768, 32767, 0, 1);
        default: write_all($urandom_range(0, 255), $urandom_range(0, 65535),
                           $signed(16'($urandom)), $signed(16'($urandom)),
                           $signed(16'($urandom)), $urandom_range(1, 24'hFFFFFF));
      endcase
      no_idle = (ph == 3);
      for (int k = 0; k < 190; k++) pending_words.push_back(random_sample());
      drain();
    end
    $display("Sent %0d samples over 6 register settings, checked %0d results", words_sent,
             words_seen);
    $display("Range steps seen: %0d", range_moves);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
